@@ hw/rtl/ptfd_pkg.sv @@
// ----------------------------------------------------------------------------
// ptfd_pkg: shared types and constants of the packed temporal field decoder
// Cell kinds, input/result structs and the fixed arithmetic constants.
// ----------------------------------------------------------------------------
package ptfd_pkg;

    // Cell kind carried alongside each input word
    typedef enum logic [1:0] {
        FMT_DATETIME2  = 2'd0,
        FMT_TIME2      = 2'd1,
        FMT_TIMESTAMP2 = 2'd2,
        FMT_TIMESTAMP  = 2'd3
    } fmt_t;

    // Year field bias and month divisor of the datetime2 layout
    localparam logic [17:0] YEAR_BIAS   = 18'd131073;
    localparam logic [3:0]  MONTH_DIV   = 4'd13;
    localparam logic [3:0]  MONTH_LAST  = 4'd12;

    // Reciprocal of 13 for 17-bit dividends: ceil(2^22 / 13), exact over range
    localparam logic [18:0] DIV13_RECIP = 19'd322639;
    localparam int          DIV13_SHIFT = 22;

    // Fraction scaling per precision group
    localparam logic [2:0]  PREC_MAX     = 3'd6;
    localparam logic [13:0] FRAC_SCALE_1 = 14'd10000;
    localparam logic [6:0]  FRAC_SCALE_2 = 7'd100;

    // Timestamp seconds to microseconds
    localparam logic [19:0] USEC_PER_SEC = 20'd1000000;

    typedef struct packed {
        logic [23:0] fraction_raw;
        logic [2:0]  precision;
        logic [39:0] packed_value;
        fmt_t        format;
    } in_t;

    typedef struct packed {
        logic        error_out;
        logic [51:0] epoch_out;
        logic        negative_out;
        logic [23:0] micro_out;
        logic [5:0]  second_out;
        logic [5:0]  minute_out;
        logic [9:0]  hour_out;
        logic [4:0]  day_out;
        logic [3:0]  month_out;
        logic [13:0] year_out;
    } res_t;

endpackage

@@ hw/rtl/packed_temporal_field_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// packed_temporal_field_decoder_unit: packed temporal cell decoder
// Stream in one packed cell per word, stream out its decoded fields.
// ----------------------------------------------------------------------------
// Decodes one packed database temporal cell per input word into calendar and
// clock fields, a scaled fraction, or an epoch count. The kind arrives on
// s_tuser: datetime2 yields year, month, day, hour, minute, second and
// microseconds; time2 yields a sign flag, ten-bit hours, minutes, seconds and
// microseconds; timestamp2 yields whole seconds and timestamp yields
// microseconds in epoch. A precision above six (datetime2, time2) or a
// datetime2 year field below its bias rejects the cell: m_tuser goes high and
// every tdata field reads zero. The block keeps no state between words.
// Throughput is one word per clock while m_tready holds. A word accepted
// is held in the input register, and its decode (a reciprocal multiply for
// divide-by-13 and a 32x20 multiply for timestamps) is captured in the
// result register, from which it is offered on the output. Either side may
// stall freely.
// ----------------------------------------------------------------------------
module packed_temporal_field_decoder_unit (
    input  logic         aclk,
    input  logic         aresetn,

    input  logic         s_tvalid,
    output logic         s_tready,
    // [39:0] packed_value, [42:40] precision, [66:43] fraction_raw, [71:67] zero
    input  logic [71:0]  s_tdata,
    // [1:0] format
    input  logic [1:0]   s_tuser,

    output logic         m_tvalid,
    input  logic         m_tready,
    // [13:0] year_out, [17:14] month_out, [22:18] day_out, [32:23] hour_out,
    // [38:33] minute_out, [44:39] second_out, [68:45] micro_out,
    // [69] negative_out, [121:70] epoch_out, [127:122] zero
    output logic [127:0] m_tdata,
    // [0] error_out
    output logic         m_tuser
);

    ptfd_pkg::in_t  in_next;
    ptfd_pkg::in_t  in_reg;
    logic           in_valid_next;
    logic           in_valid_reg;

    ptfd_pkg::res_t res_next;
    ptfd_pkg::res_t res_reg;
    logic           out_valid_next;
    logic           out_valid_reg;

    logic           out_advance;
    logic           in_load;
    logic           out_load;

    // Result stage moves when empty or when its word is taken
    assign out_advance = ~out_valid_reg | m_tready;
    // Input stage takes a word when empty or when it can hand off
    assign s_tready    = ~in_valid_reg | out_advance;
    assign in_load     = s_tvalid & s_tready;
    assign out_load    = in_valid_reg & out_advance;

    // Unpack the input word
    always_comb begin
        in_next.format       = ptfd_pkg::fmt_t'(s_tuser);
        in_next.packed_value = s_tdata[39:0];
        in_next.precision    = s_tdata[42:40];
        in_next.fraction_raw = s_tdata[66:43];
    end

    assign in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
    assign out_valid_next = out_advance ? in_valid_reg : out_valid_reg;

    // Control: valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: hold while stalled, advance on load
    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_reg <= in_next;
        end
        if (out_load) begin
            res_reg <= res_next;
        end
    end

    ptfd_decode u_decode (
        .cell_in (in_reg),
        .res     (res_next)
    );

    // Pack the result word
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = res_reg.error_out;
    assign m_tdata  = {6'b000000,
                       res_reg.epoch_out,
                       res_reg.negative_out,
                       res_reg.micro_out,
                       res_reg.second_out,
                       res_reg.minute_out,
                       res_reg.hour_out,
                       res_reg.day_out,
                       res_reg.month_out,
                       res_reg.year_out};

endmodule

@@ hw/rtl/ptfd_year_div.sv @@
// ----------------------------------------------------------------------------
// ptfd_year_div: year and month from the debiased datetime2 leading field
// Divide by 13 through a reciprocal multiply, then fold the remainder.
// ----------------------------------------------------------------------------
module ptfd_year_div (
    input  logic [16:0] year_field,   // leading field minus bias
    output logic [13:0] year,
    output logic [3:0]  month
);

    logic [35:0] prod;
    logic [17:0] q13;
    logic [17:0] rem_full;
    logic [3:0]  rem;

    always_comb begin
        prod     = 36'(year_field) * 36'(ptfd_pkg::DIV13_RECIP);
        year     = prod[ptfd_pkg::DIV13_SHIFT +: 14];
        // year * 13 as shift-add
        q13      = {1'b0, year, 3'b000} + {2'b00, year, 2'b00} + {4'b0000, year};
        rem_full = {1'b0, year_field} - q13;
        rem      = rem_full[3:0];
        // (field + bias + 7) mod 13 == (rem + 1) mod 13
        if (rem == ptfd_pkg::MONTH_LAST) begin
            month = '0;
        end else begin
            month = rem + 4'd1;
        end
    end

endmodule

@@ hw/rtl/ptfd_frac_scale.sv @@
// ----------------------------------------------------------------------------
// ptfd_frac_scale: fractional seconds scaled to microseconds
// Byte count and scale factor follow the precision group.
// ----------------------------------------------------------------------------
module ptfd_frac_scale (
    input  logic [2:0]  precision,
    input  logic [23:0] fraction_raw,
    output logic [23:0] micro
);

    logic [21:0] p_one;
    logic [22:0] p_two;

    always_comb begin
        p_one = 22'(fraction_raw[7:0]) * 22'(ptfd_pkg::FRAC_SCALE_1);
        p_two = 23'(fraction_raw[15:0]) * 23'(ptfd_pkg::FRAC_SCALE_2);
        unique case (precision)
            3'd0:       micro = '0;
            3'd1, 3'd2: micro = 24'(p_one);
            3'd3, 3'd4: micro = 24'(p_two);
            default:    micro = fraction_raw;  // five and six; seven is rejected upstream
        endcase
    end

endmodule

@@ hw/rtl/ptfd_decode.sv @@
// ----------------------------------------------------------------------------
// ptfd_decode: combinational decode of one packed temporal cell
// Selects the field split per cell kind and applies the reject guard.
// ----------------------------------------------------------------------------
module ptfd_decode (
    input  ptfd_pkg::in_t  cell_in,
    output ptfd_pkg::res_t res
);

    logic [17:0] lead;
    logic [17:0] lead_debias;
    logic        below_bias;
    logic        prec_bad;
    logic [13:0] year;
    logic [3:0]  month;
    logic [23:0] micro;
    logic [23:0] t2_raw;
    logic        t2_neg;
    logic [23:0] t2_mag;
    logic [31:0] ts_le;
    logic [51:0] ts_usec;

    assign lead        = cell_in.packed_value[39:22];
    assign below_bias  = lead < ptfd_pkg::YEAR_BIAS;
    assign lead_debias = lead - ptfd_pkg::YEAR_BIAS;
    assign prec_bad    = cell_in.precision > ptfd_pkg::PREC_MAX;

    ptfd_year_div u_year_div (
        .year_field (lead_debias[16:0]),
        .year       (year),
        .month      (month)
    );

    ptfd_frac_scale u_frac_scale (
        .precision    (cell_in.precision),
        .fraction_raw (cell_in.fraction_raw),
        .micro        (micro)
    );

    // time2: clear top bit marks a negative value, stored in two's complement
    assign t2_raw = cell_in.packed_value[23:0];
    assign t2_neg = ~t2_raw[23];
    assign t2_mag = t2_neg ? (~t2_raw + 24'd1) : t2_raw;

    // timestamp: bytes reversed, low byte of packed_value is most significant
    assign ts_le   = {cell_in.packed_value[7:0], cell_in.packed_value[15:8],
                      cell_in.packed_value[23:16], cell_in.packed_value[31:24]};
    assign ts_usec = 52'(ts_le) * 52'(ptfd_pkg::USEC_PER_SEC);

    always_comb begin
        res = '0;
        unique case (cell_in.format)
            ptfd_pkg::FMT_DATETIME2: begin
                if (prec_bad || below_bias) begin
                    res.error_out = 1'b1;
                end else begin
                    res.year_out   = year;
                    res.month_out  = month;
                    res.day_out    = cell_in.packed_value[21:17];
                    res.hour_out   = {5'b00000, cell_in.packed_value[16:12]};
                    res.minute_out = cell_in.packed_value[11:6];
                    res.second_out = cell_in.packed_value[5:0];
                    res.micro_out  = micro;
                end
            end
            ptfd_pkg::FMT_TIME2: begin
                if (prec_bad) begin
                    res.error_out = 1'b1;
                end else begin
                    res.hour_out     = t2_mag[21:12];
                    res.minute_out   = t2_mag[11:6];
                    res.second_out   = t2_mag[5:0];
                    res.micro_out    = micro;
                    res.negative_out = t2_neg;
                end
            end
            ptfd_pkg::FMT_TIMESTAMP2: begin
                res.epoch_out = 52'(cell_in.packed_value[31:0]);
            end
            ptfd_pkg::FMT_TIMESTAMP: begin
                res.epoch_out = ts_usec;
            end
        endcase
    end

endmodule
